@@ rtl/ysc_pkg.sv @@
// Shared types, constants and helper functions for the YCbCr skin classifier.
package ysc_pkg;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned COEF_W   = 10;
    localparam int unsigned PROD_W   = PIX_W + COEF_W;
    localparam int unsigned SUM_W    = PROD_W + 3;
    localparam int unsigned FRAC_W   = 10;
    localparam int unsigned CFG_IDX_W = 2;

    // BT.601 coefficients scaled by 1024
    localparam logic [COEF_W-1:0] K_Y_R  = COEF_W'(263);
    localparam logic [COEF_W-1:0] K_Y_G  = COEF_W'(516);
    localparam logic [COEF_W-1:0] K_Y_B  = COEF_W'(100);
    localparam logic [COEF_W-1:0] K_CB_R = COEF_W'(152);
    localparam logic [COEF_W-1:0] K_CB_G = COEF_W'(298);
    localparam logic [COEF_W-1:0] K_CB_B = COEF_W'(450);
    localparam logic [COEF_W-1:0] K_CR_R = COEF_W'(450);
    localparam logic [COEF_W-1:0] K_CR_G = COEF_W'(377);
    localparam logic [COEF_W-1:0] K_CR_B = COEF_W'(73);

    // Offsets scaled by 1024, with the rounding half already folded in
    localparam logic signed [SUM_W-1:0] OFS_Y_RND = SUM_W'(16 * 1024 + 512);
    localparam logic signed [SUM_W-1:0] OFS_C_RND = SUM_W'(128 * 1024 + 512);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_CB  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_CR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_RANGE = 2'd2;

    localparam logic [PIX_W-1:0] RST_CENTER_CB  = 8'd120;
    localparam logic [PIX_W-1:0] RST_CENTER_CR  = 8'd155;
    localparam logic [PIX_W-1:0] RST_HALF_RANGE = 8'd22;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic             is_skin;
    } pixel_out_t;

    // Nine partial products, magnitudes only; signs applied in the sum stage
    typedef struct packed {
        logic [PROD_W-1:0] y_r;
        logic [PROD_W-1:0] y_g;
        logic [PROD_W-1:0] y_b;
        logic [PROD_W-1:0] cb_r;
        logic [PROD_W-1:0] cb_g;
        logic [PROD_W-1:0] cb_b;
        logic [PROD_W-1:0] cr_r;
        logic [PROD_W-1:0] cr_g;
        logic [PROD_W-1:0] cr_b;
    } prod_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
    } ycc_t;

    typedef struct packed {
        logic [PIX_W-1:0] center_cb;
        logic [PIX_W-1:0] center_cr;
        logic [PIX_W-1:0] half_range;
    } box_cfg_t;

    // Drop the fraction and clamp to 0..255
    function automatic logic [PIX_W-1:0] to_pixel(input logic signed [SUM_W-1:0] sum);
        logic [SUM_W-FRAC_W-1:0] whole;
        whole = sum[SUM_W-1:FRAC_W];
        if (sum < 0)
            return '0;
        else if (whole > (SUM_W-FRAC_W)'(255))
            return '1;
        else
            return whole[PIX_W-1:0];
    endfunction

    // centre - half < v < centre + half, rearranged to stay unsigned
    function automatic logic in_band(input logic [PIX_W-1:0] v,
                                     input logic [PIX_W-1:0] centre,
                                     input logic [PIX_W-1:0] half);
        logic [PIX_W:0] v_plus_h;
        logic [PIX_W:0] c_plus_h;
        v_plus_h = {1'b0, v} + {1'b0, half};
        c_plus_h = {1'b0, centre} + {1'b0, half};
        return (v_plus_h > {1'b0, centre}) && ({1'b0, v} < c_plus_h);
    endfunction

endpackage

@@ rtl/ysc_mult.sv @@
// First pipeline stage: constant-coefficient partial products.
module ysc_mult (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               valid_in,
    input  ysc_pkg::pixel_in_t data_in,
    output logic               valid,
    output ysc_pkg::prod_t     data
);

    logic           valid_reg;
    ysc_pkg::prod_t data_reg;
    ysc_pkg::prod_t data_next;

    function automatic logic [ysc_pkg::PROD_W-1:0] mul(
        input logic [ysc_pkg::PIX_W-1:0]  x,
        input logic [ysc_pkg::COEF_W-1:0] k);
        return ysc_pkg::PROD_W'(x) * ysc_pkg::PROD_W'(k);
    endfunction

    always_comb
    begin
        data_next.y_r  = mul(data_in.red,   ysc_pkg::K_Y_R);
        data_next.y_g  = mul(data_in.green, ysc_pkg::K_Y_G);
        data_next.y_b  = mul(data_in.blue,  ysc_pkg::K_Y_B);
        data_next.cb_r = mul(data_in.red,   ysc_pkg::K_CB_R);
        data_next.cb_g = mul(data_in.green, ysc_pkg::K_CB_G);
        data_next.cb_b = mul(data_in.blue,  ysc_pkg::K_CB_B);
        data_next.cr_r = mul(data_in.red,   ysc_pkg::K_CR_R);
        data_next.cr_g = mul(data_in.green, ysc_pkg::K_CR_G);
        data_next.cr_b = mul(data_in.blue,  ysc_pkg::K_CR_B);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ rtl/ysc_round.sv @@
// Second pipeline stage: signed sums, rounding and saturation to 8 bits.
module ysc_round (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           valid_in,
    input  ysc_pkg::prod_t data_in,
    output logic           valid,
    output ysc_pkg::ycc_t  data
);

    logic                               valid_reg;
    ysc_pkg::ycc_t                      data_reg;
    ysc_pkg::ycc_t                      data_next;
    logic signed [ysc_pkg::SUM_W-1:0]   sum_y;
    logic signed [ysc_pkg::SUM_W-1:0]   sum_cb;
    logic signed [ysc_pkg::SUM_W-1:0]   sum_cr;

    always_comb
    begin
        sum_y  = ysc_pkg::OFS_Y_RND
               + $signed(ysc_pkg::SUM_W'(data_in.y_r))
               + $signed(ysc_pkg::SUM_W'(data_in.y_g))
               + $signed(ysc_pkg::SUM_W'(data_in.y_b));
        sum_cb = ysc_pkg::OFS_C_RND
               - $signed(ysc_pkg::SUM_W'(data_in.cb_r))
               - $signed(ysc_pkg::SUM_W'(data_in.cb_g))
               + $signed(ysc_pkg::SUM_W'(data_in.cb_b));
        sum_cr = ysc_pkg::OFS_C_RND
               + $signed(ysc_pkg::SUM_W'(data_in.cr_r))
               - $signed(ysc_pkg::SUM_W'(data_in.cr_g))
               - $signed(ysc_pkg::SUM_W'(data_in.cr_b));
        data_next.luma        = ysc_pkg::to_pixel(sum_y);
        data_next.chroma_blue = ysc_pkg::to_pixel(sum_cb);
        data_next.chroma_red  = ysc_pkg::to_pixel(sum_cr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ rtl/ysc_band.sv @@
// Third pipeline stage: chroma box test and the output register.
module ysc_band (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                valid_in,
    input  ysc_pkg::ycc_t       data_in,
    input  ysc_pkg::box_cfg_t   box,
    output logic                valid,
    output ysc_pkg::pixel_out_t data
);

    logic                valid_reg;
    ysc_pkg::pixel_out_t data_reg;
    ysc_pkg::pixel_out_t data_next;

    always_comb
    begin
        data_next.luma        = data_in.luma;
        data_next.chroma_blue = data_in.chroma_blue;
        data_next.chroma_red  = data_in.chroma_red;
        data_next.is_skin     =
            ysc_pkg::in_band(data_in.chroma_blue, box.center_cb, box.half_range) &&
            ysc_pkg::in_band(data_in.chroma_red,  box.center_cr, box.half_range);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ rtl/ycbcr_skin_classifier_top.sv @@
// Top level of the BT.601 YCbCr converter with chroma-box skin classifier.
//
// Input channel: one RGB pixel per transfer on in_valid/in_ready/in_data.
// Output channel: one result per pixel on out_valid/out_ready/out_data,
// carrying Y, Cb, Cr (rounded half up, clamped to 0..255) and the skin flag.
// Configuration: cfg_wr_en writes cfg_data into the register at cfg_index
// (0 centre Cb, 1 centre Cr, 2 half range); other indexes are ignored.
// Write registers only while no pixel is in flight.
//
// Pipeline: three register stages; a pixel moves from the product register to the
// sum register and then to the output register, where it is offered.
// Stage one forms the nine constant products, stage two sums, rounds and
// clamps, stage three runs the box test and is the output register.
// Throughput: one pixel per cycle while the receiver keeps out_ready high.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and a stalled receiver fills the pipe before in_ready drops.
// Reset empties all stages and loads the box registers with 120, 155 and 22.
module ycbcr_skin_classifier_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ysc_pkg::pixel_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ysc_pkg::pixel_out_t               out_data,
    input  logic                              cfg_wr_en,
    input  logic [ysc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ysc_pkg::PIX_W-1:0]         cfg_data
);

    ysc_pkg::box_cfg_t box_reg;

    logic           mult_valid;
    ysc_pkg::prod_t mult_data;
    logic           round_valid;
    ysc_pkg::ycc_t  round_data;

    logic adv_mult;
    logic adv_round;
    logic adv_band;

    // Advance chain: a stage may load when it is empty or its contents move on
    assign adv_band  = !out_valid   || out_ready;
    assign adv_round = !round_valid || adv_band;
    assign adv_mult  = !mult_valid  || adv_round;
    assign in_ready  = adv_mult;

    // Box registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.center_cb  <= ysc_pkg::RST_CENTER_CB;
            box_reg.center_cr  <= ysc_pkg::RST_CENTER_CR;
            box_reg.half_range <= ysc_pkg::RST_HALF_RANGE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ysc_pkg::CFG_CENTER_CB:  box_reg.center_cb  <= cfg_data;
                ysc_pkg::CFG_CENTER_CR:  box_reg.center_cr  <= cfg_data;
                ysc_pkg::CFG_HALF_RANGE: box_reg.half_range <= cfg_data;
                default: ; // unused index: drop the write
            endcase
        end
    end

    ysc_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (adv_mult),
        .valid_in (in_valid),
        .data_in  (in_data),
        .valid    (mult_valid),
        .data     (mult_data)
    );

    ysc_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (adv_round),
        .valid_in (mult_valid),
        .data_in  (mult_data),
        .valid    (round_valid),
        .data     (round_data)
    );

    ysc_band u_band (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (adv_band),
        .valid_in (round_valid),
        .data_in  (round_data),
        .box      (box_reg),
        .valid    (out_valid),
        .data     (out_data)
    );

`ifndef NO_ASSERTIONS
    // A full pipe behind a stalled receiver must refuse new pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        (mult_valid && round_valid && out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while every stage is full and stalled");

    // An accepted pixel always lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> mult_valid)
        else $error("accepted pixel lost at the first stage");

    // Studio range: Y in 16..235, Cb in 16..240 for any 8-bit RGB
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.luma >= 8'd16) && (out_data.luma <= 8'd235) &&
                      (out_data.chroma_blue >= 8'd16) && (out_data.chroma_blue <= 8'd240))
        else $error("converted value outside studio range");
`endif

endmodule

@@ verif/ycbcr_skin_classifier_top_tb.sv @@
// Self-checking testbench for the YCbCr skin classifier: directed pixels, then random ones.
module ycbcr_skin_classifier_top_tb;

    localparam int CLK_HALF     = 10;
    localparam int PIPE_DEPTH   = 3;
    localparam int ROW_COUNT    = 15;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_PIXELS = 49;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_LIMIT  = 10000;
    localparam int RUN_CYCLES   = 400000;

    // Index 3 decodes to no register; writes to it must leave the box alone
    localparam logic [ysc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Conversion constants, scaled by 1024
    localparam int Y_R = 263;
    localparam int Y_G = 516;
    localparam int Y_B = 100;
    localparam int CB_R = 152;
    localparam int CB_G = 298;
    localparam int CB_B = 450;
    localparam int CR_R = 450;
    localparam int CR_G = 377;
    localparam int CR_B = 73;
    localparam int Y_BASE = 16 * 1024;
    localparam int C_BASE = 128 * 1024;
    localparam int ROUND_HALF = 512;

    typedef struct packed {
        ysc_pkg::pixel_in_t  px;
        logic                fixed;
        ysc_pkg::pixel_out_t result;
    } pixel_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    ysc_pkg::pixel_in_t            in_data;
    logic                          out_valid;
    logic                          out_ready;
    ysc_pkg::pixel_out_t           out_data;
    logic                          cfg_wr_en;
    logic [ysc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ysc_pkg::PIX_W-1:0]     cfg_data;

    // Own copy of the box registers, kept in step with every write
    ysc_pkg::box_cfg_t   box;
    // Results still owed by the block, oldest first
    ysc_pkg::pixel_out_t ycc_pending[$];
    ysc_pkg::pixel_out_t ycc_head;
    pixel_row_t          pixel_rows[ROW_COUNT];

    // A directed row with a typed-in result pins the expectation for its transfer
    bit                  pinned_valid;
    ysc_pkg::pixel_out_t pinned_result;

    int send_idle_pct;
    int recv_idle_pct;
    int pixels_sent;
    int checked_count;
    int skin_count;
    int mismatch_count;
    int box_settings;

    ycbcr_skin_classifier_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Round-half-up is already in the sum; drop the fraction and clamp to 0..255
    function automatic logic [ysc_pkg::PIX_W-1:0] clamp_scaled(input int sum);
        int whole;
        if (sum < 0)
            return '0;
        whole = sum >>> 10;
        if (whole > 255)
            return 8'hFF;
        return whole[ysc_pkg::PIX_W-1:0];
    endfunction

    // Both bounds exclusive, compared as full signed integers
    function automatic bit chroma_inside(input int v, input int centre, input int half);
        return (v > centre - half) && (v < centre + half);
    endfunction

    function automatic ysc_pkg::pixel_out_t ycc_classify(input ysc_pkg::pixel_in_t px);
        int                  r;
        int                  g;
        int                  b;
        ysc_pkg::pixel_out_t res;
        r = int'(px.red);
        g = int'(px.green);
        b = int'(px.blue);
        res.luma        = clamp_scaled(Y_BASE + ROUND_HALF + Y_R * r + Y_G * g + Y_B * b);
        res.chroma_blue = clamp_scaled(C_BASE + ROUND_HALF - CB_R * r - CB_G * g + CB_B * b);
        res.chroma_red  = clamp_scaled(C_BASE + ROUND_HALF + CR_R * r - CR_G * g - CR_B * b);
        res.is_skin = chroma_inside(int'(res.chroma_blue), int'(box.center_cb),
                                    int'(box.half_range)) &&
                      chroma_inside(int'(res.chroma_red), int'(box.center_cr),
                                    int'(box.half_range));
        return res;
    endfunction

    // Half of the pixels uniform, the rest skin tones, greys and saturated corners
    function automatic ysc_pkg::pixel_in_t pick_pixel();
        ysc_pkg::pixel_in_t px;
        int                 style;
        int                 r;
        int                 g;
        int                 b;
        style = $urandom_range(9);
        px.red   = 8'($urandom_range(255));
        px.green = 8'($urandom_range(255));
        px.blue  = 8'($urandom_range(255));
        case (style)
            5, 6, 7:
            begin
                r = $urandom_range(255, 130);
                g = r - $urandom_range(70, 15);
                b = g - $urandom_range(50, 0);
                px.red   = r[7:0];
                px.green = g[7:0];
                px.blue  = b[7:0];
            end
            8:
            begin
                px.green = px.red;
                px.blue  = px.red;
            end
            9:
            begin
                px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
                px.green = $urandom_range(1) ? 8'hFF : 8'h00;
                px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            default:
            begin
            end
        endcase
        return px;
    endfunction

    // Offer one pixel and hold it until the transfer happens
    task automatic send_pixel(input ysc_pkg::pixel_in_t px);
        // Idling pattern follows the progress of the run: sender light and
        // receiver heavy, then the reverse, then a stretch with no idling at all
        if (pixels_sent < 170)
        begin
            send_idle_pct = 21;
            recv_idle_pct = 77;
        end
        else if (pixels_sent < 340)
        begin
            send_idle_pct = 77;
            recv_idle_pct = 21;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= px;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every owed result has arrived, then let the pipe settle
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (ycc_pending.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 1) @(negedge clk);
    endtask

    // Write all three box registers back to back; keep the enable high throughout
    task automatic apply_box(input logic [ysc_pkg::PIX_W-1:0] cb,
                             input logic [ysc_pkg::PIX_W-1:0] cr,
                             input logic [ysc_pkg::PIX_W-1:0] half, input bit poke_unused);
        cfg_wr_en <= 1'b1;
        cfg_index <= ysc_pkg::CFG_CENTER_CB;
        cfg_data  <= cb;
        @(negedge clk);
        cfg_index <= ysc_pkg::CFG_CENTER_CR;
        cfg_data  <= cr;
        @(negedge clk);
        cfg_index <= ysc_pkg::CFG_HALF_RANGE;
        cfg_data  <= half;
        @(negedge clk);
        if (poke_unused)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= 8'($urandom_range(255));
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        box.center_cb  = cb;
        box.center_cr  = cr;
        box.half_range = half;
        box_settings++;
        @(negedge clk);
    endtask

    // Receiver: decide readiness for the next edge at each falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Scoreboard: check the result transfer first, then book the input transfer.
    // A pixel accepted at this edge cannot come out at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (ycc_pending.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("ERROR: result with nothing owed: Y=%0d Cb=%0d Cr=%0d skin=%0b",
                                 out_data.luma, out_data.chroma_blue, out_data.chroma_red,
                                 out_data.is_skin);
                end
                else
                begin
                    ycc_head = ycc_pending.pop_front();
                    checked_count++;
                    if (out_data.is_skin === 1'b1)
                        skin_count++;
                    if (out_data.luma !== ycc_head.luma ||
                        out_data.chroma_blue !== ycc_head.chroma_blue ||
                        out_data.chroma_red !== ycc_head.chroma_red ||
                        out_data.is_skin !== ycc_head.is_skin)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $write("ERROR: result %0d: expected Y=%0d Cb=%0d Cr=%0d skin=%0b,",
                                   checked_count, ycc_head.luma, ycc_head.chroma_blue,
                                   ycc_head.chroma_red, ycc_head.is_skin);
                            $display(" got Y=%0d Cb=%0d Cr=%0d skin=%0b", out_data.luma,
                                     out_data.chroma_blue, out_data.chroma_red,
                                     out_data.is_skin);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (pinned_valid)
                    ycc_pending.insert(ycc_pending.size(), pinned_result);
                else
                    ycc_pending.insert(ycc_pending.size(), ycc_classify(in_data));
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        int n;
        int drain_guard;
        logic [ysc_pkg::PIX_W-1:0] rand_half;

        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = ysc_pkg::CFG_CENTER_CB;
        cfg_data       = '0;
        pinned_valid   = 1'b0;
        pinned_result  = '0;
        send_idle_pct  = 21;
        recv_idle_pct  = 77;
        pixels_sent    = 0;
        checked_count  = 0;
        skin_count     = 0;
        mismatch_count = 0;
        box_settings   = 1;
        box = '{center_cb: 8'd120, center_cr: 8'd155, half_range: 8'd22};

        // Directed pixels under the reset box. Black and white are pinned: both
        // land on Cb = Cr = 128, inside the Cb band but below the Cr band.
        pixel_rows[0]  = '{'{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd16, 8'd128, 8'd128, 1'b0}};
        pixel_rows[1]  = '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd235, 8'd128, 8'd128, 1'b0}};
        pixel_rows[2]  = '{'{8'd255, 8'd0, 8'd0}, 1'b0, '0};
        pixel_rows[3]  = '{'{8'd0, 8'd255, 8'd0}, 1'b0, '0};
        pixel_rows[4]  = '{'{8'd0, 8'd0, 8'd255}, 1'b0, '0};
        pixel_rows[5]  = '{'{8'd255, 8'd255, 8'd0}, 1'b0, '0};
        pixel_rows[6]  = '{'{8'd0, 8'd255, 8'd255}, 1'b0, '0};
        pixel_rows[7]  = '{'{8'd255, 8'd0, 8'd255}, 1'b0, '0};
        pixel_rows[8]  = '{'{8'd128, 8'd128, 8'd128}, 1'b0, '0};
        pixel_rows[9]  = '{'{8'd200, 8'd150, 8'd120}, 1'b0, '0};
        pixel_rows[10] = '{'{8'd224, 8'd172, 8'd140}, 1'b0, '0};
        pixel_rows[11] = '{'{8'hAA, 8'h55, 8'hAA}, 1'b0, '0};
        pixel_rows[12] = '{'{8'h55, 8'hAA, 8'h55}, 1'b0, '0};
        pixel_rows[13] = '{'{8'd1, 8'd1, 8'd1}, 1'b0, '0};
        pixel_rows[14] = '{'{8'd254, 8'd254, 8'd254}, 1'b0, '0};

        // Single reset pulse, released on a falling edge
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (n = 0; n < ROW_COUNT; n++)
        begin
            pinned_valid  = pixel_rows[n].fixed;
            pinned_result = pixel_rows[n].result;
            send_pixel(pixel_rows[n].px);
        end
        pinned_valid = 1'b0;

        // Random phases, each under its own box. Every phase starts from an
        // empty pipe, so the sender is forced to wait out all owed results.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_pipe();
            case (phase)
                // Greys give Cb = Cr = 128: a one-wide box around it accepts them
                0: apply_box(8'd128, 8'd128, 8'd1, 1'b0);
                // 128 sits exactly on the lower Cb and upper Cr bound: rejected
                1: apply_box(8'd150, 8'd106, 8'd22, 1'b1);
                // Lower bounds below zero never exclude anything
                2: apply_box(8'd0, 8'd0, 8'd255, 1'b0);
                // Upper bounds above 255 never exclude anything
                3: apply_box(8'd255, 8'd255, 8'd255, 1'b1);
                // Empty box: nothing is skin
                4: apply_box(8'd255, 8'd0, 8'd0, 1'b0);
                // Back to the reset values, with a stray write to the unused index
                5: apply_box(8'd120, 8'd155, 8'd22, 1'b1);
                default:
                begin
                    rand_half = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                         : 8'($urandom_range(60, 1));
                    apply_box(8'($urandom_range(255)), 8'($urandom_range(255)), rand_half,
                              phase[0]);
                end
            endcase
            for (n = 0; n < PHASE_PIXELS; n++)
                send_pixel(pick_pixel());
        end

        // Drop valid and wait for the pipe to empty, within a bound
        in_valid <= 1'b0;
        drain_guard = 0;
        while (ycc_pending.size() != 0 && drain_guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain_guard++;
        end
        repeat (PIPE_DEPTH + 2) @(negedge clk);
        // Anything still owed counts against the block
        mismatch_count += ycc_pending.size();

        $display("Summary: %0d pixels sent, %0d results checked, %0d flagged as skin",
                 pixels_sent, checked_count, skin_count);
        $display("Summary: %0d box settings, %0d failures", box_settings, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: end a hung run
    initial
    begin
        #(2 * CLK_HALF * RUN_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
